>>> hw/rtl/lc2k_pkg.sv
// Shared types, constants and control-word layout for the LC-2K executor.
// Used by lc2k_seq, lc2k_datapath and lc2k_instruction_executor.
`default_nettype none

package lc2k_pkg;

  // Word memory size; a power of two so that address and pc wrap by truncation
  localparam int MEM_WORDS = 65536;
  localparam int MEM_AW    = $clog2(MEM_WORDS);

  // Instruction word field positions
  localparam int OPC_LSB = 22;
  localparam int RA_LSB  = 19;
  localparam int RB_LSB  = 16;
  localparam int OFF_W   = 16;
  localparam int IR_W    = 25;

  typedef logic [31:0]       word_t;
  typedef logic [MEM_AW-1:0] maddr_t;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_NOR  = 3'd1,
    OP_LW   = 3'd2,
    OP_SW   = 3'd3,
    OP_BEQ  = 3'd4,
    OP_JALR = 3'd5,
    OP_HALT = 3'd6,
    OP_NOOP = 3'd7
  } opcode_t;

  // Microprogram step addresses
  typedef enum logic [3:0] {
    U_IDLE   = 4'd0,
    U_LOAD   = 4'd1,
    U_SKIP   = 4'd2,
    U_DECODE = 4'd3,
    U_EXEC   = 4'd4,
    U_ALU    = 4'd5,
    U_LW_RD  = 4'd6,
    U_LW_WB  = 4'd7,
    U_SW     = 4'd8,
    U_PLAIN  = 4'd9,
    U_JALR   = 4'd10,
    U_HALT   = 4'd11
  } uaddr_t;

  typedef enum logic [1:0] {
    NX_SEQ      = 2'd0,
    NX_START    = 2'd1,
    NX_DISPATCH = 2'd2,
    NX_IDLE     = 2'd3
  } next_sel_t;

  typedef enum logic [1:0] {
    MEM_NONE     = 2'd0,
    MEM_WR_LOAD  = 2'd1,
    MEM_WR_STORE = 2'd2,
    MEM_RD_EA    = 2'd3
  } mem_op_t;

  typedef enum logic [1:0] {
    RF_NONE = 2'd0,
    RF_ALU  = 2'd1,
    RF_MEMQ = 2'd2,
    RF_LINK = 2'd3
  } rf_src_t;

  // Datapath control for one step
  typedef struct packed {
    logic    accept;
    mem_op_t mem_op;
    logic    dec;
    logic    exec;
    rf_src_t rf_src;
    logic    halt_set;
    logic    finish;
    logic    commit;
  } ctrl_t;

  // One microprogram word
  typedef struct packed {
    ctrl_t     ctl;
    next_sel_t nx;
  } ucode_t;

  // Datapath status seen by the sequencer
  typedef struct packed {
    opcode_t opcode;
    logic    halted;
  } status_t;

endpackage

`default_nettype wire

>>> hw/rtl/lc2k_seq.sv
// Microcode sequencer: step counter, control-word ROM and opcode dispatch.
// Depends on lc2k_pkg.
`default_nettype none

module lc2k_seq (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic              op,
  input  wire lc2k_pkg::status_t stat,
  output      lc2k_pkg::ctrl_t   ctrl,
  output      logic              busy
);
  import lc2k_pkg::*;

  uaddr_t upc;
  uaddr_t upc_next;
  ucode_t uw;

  // Control store
  function automatic ucode_t rom(input uaddr_t a);
    ucode_t w;
    w = '0;
    w.ctl.mem_op = MEM_NONE;
    w.ctl.rf_src = RF_NONE;
    w.nx         = NX_IDLE;
    case (a)
      U_IDLE: begin
        w.nx = NX_START;
      end
      U_LOAD: begin
        w.ctl.mem_op = MEM_WR_LOAD;
        w.ctl.finish = 1'b1;
      end
      U_SKIP: begin
        w.ctl.finish = 1'b1;
      end
      U_DECODE: begin
        w.ctl.dec = 1'b1;
        w.nx      = NX_SEQ;
      end
      U_EXEC: begin
        w.ctl.exec = 1'b1;
        w.nx       = NX_DISPATCH;
      end
      U_ALU: begin
        w.ctl.rf_src = RF_ALU;
        w.ctl.finish = 1'b1;
        w.ctl.commit = 1'b1;
      end
      U_LW_RD: begin
        w.ctl.mem_op = MEM_RD_EA;
        w.nx         = NX_SEQ;
      end
      U_LW_WB: begin
        w.ctl.rf_src = RF_MEMQ;
        w.ctl.finish = 1'b1;
        w.ctl.commit = 1'b1;
      end
      U_SW: begin
        w.ctl.mem_op = MEM_WR_STORE;
        w.ctl.finish = 1'b1;
        w.ctl.commit = 1'b1;
      end
      U_PLAIN: begin
        w.ctl.finish = 1'b1;
        w.ctl.commit = 1'b1;
      end
      U_JALR: begin
        w.ctl.rf_src = RF_LINK;
        w.ctl.finish = 1'b1;
        w.ctl.commit = 1'b1;
      end
      U_HALT: begin
        w.ctl.halt_set = 1'b1;
        w.ctl.finish   = 1'b1;
        w.ctl.commit   = 1'b1;
      end
      default: begin
        w.nx = NX_IDLE;
      end
    endcase
    return w;
  endfunction

  // Opcode to first execute step
  function automatic uaddr_t dispatch(input opcode_t opc);
    uaddr_t t;
    case (opc)
      OP_ADD:  t = U_ALU;
      OP_NOR:  t = U_ALU;
      OP_LW:   t = U_LW_RD;
      OP_SW:   t = U_SW;
      OP_JALR: t = U_JALR;
      OP_HALT: t = U_HALT;
      default: t = U_PLAIN;
    endcase
    return t;
  endfunction

  // Hold step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= U_IDLE;
    end else begin
      upc <= upc_next;
    end
  end

  // Pick next step and drive control
  always_comb begin
    uw          = rom(upc);
    ctrl        = uw.ctl;
    ctrl.accept = 1'b0;
    upc_next    = upc;
    case (uw.nx)
      NX_SEQ: begin
        upc_next = uaddr_t'(upc + 4'd1);
      end
      NX_START: begin
        if (start) begin
          ctrl.accept = 1'b1;
          if (!op) begin
            upc_next = U_LOAD;
          end else if (stat.halted) begin
            upc_next = U_SKIP;
          end else begin
            upc_next = U_DECODE;
          end
        end
      end
      NX_DISPATCH: begin
        upc_next = dispatch(stat.opcode);
      end
      default: begin
        upc_next = U_IDLE;
      end
    endcase
  end

  assign busy = (upc != U_IDLE);

endmodule

`default_nettype wire

>>> hw/rtl/lc2k_datapath.sv
// Datapath: word memory, register file, instruction register, ALU, pc and step counter.
// Driven by the control word from lc2k_seq; depends on lc2k_pkg.
`default_nettype none

module lc2k_datapath (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire lc2k_pkg::ctrl_t   ctrl,
  input  wire logic [15:0]       load_address,
  input  wire logic [31:0]       load_data,
  output      lc2k_pkg::status_t stat,
  output      logic [15:0]       program_counter,
  output      logic [2:0]        executed_opcode,
  output      logic              halted,
  output      logic              address_fault,
  output      logic [31:0]       instructions_executed,
  output      logic              done
);
  import lc2k_pkg::*;

  word_t           mem [MEM_WORDS];
  word_t           mem_q;
  maddr_t          mem_ra;
  maddr_t          mem_wa;
  word_t           mem_wd;
  logic            mem_we;

  word_t           regs [8];
  logic [2:0]      rf_wa;
  word_t           rf_wd;
  logic            rf_we;

  logic [15:0]     la;
  word_t           ld;
  logic [IR_W-1:0] ir;
  word_t           a_val;
  word_t           b_val;
  word_t           alu_q;
  maddr_t          ea;
  logic            fault;
  maddr_t          next_pc;

  maddr_t          pc;
  logic            halt_flag;
  word_t           step_count;
  opcode_t         opc_out;
  logic            fault_out;

  opcode_t         opc;
  word_t           off32;
  logic [32:0]     addr33;
  maddr_t          pc_inc;

  // Decode fields of the held instruction
  assign opc    = opcode_t'(ir[OPC_LSB +: 3]);
  assign off32  = {{(32-OFF_W){ir[OFF_W-1]}}, ir[OFF_W-1:0]};
  assign addr33 = {a_val[31], a_val} + {off32[31], off32};
  assign pc_inc = pc + MEM_AW'(1);

  // Capture load beat
  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      la <= load_address;
      ld <= load_data;
    end
  end

  // Select memory access
  always_comb begin
    mem_ra = (ctrl.mem_op == MEM_RD_EA) ? ea : pc;
    mem_we = 1'b0;
    mem_wa = ea;
    mem_wd = b_val;
    case (ctrl.mem_op)
      MEM_WR_LOAD: begin
        mem_we = ({1'b0, la} < 17'(MEM_WORDS));
        mem_wa = la[MEM_AW-1:0];
        mem_wd = ld;
      end
      MEM_WR_STORE: begin
        mem_we = !fault;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Word memory; reads the pc word every idle cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    mem_q <= mem[mem_ra];
  end

  // Select register write
  always_comb begin
    rf_we = 1'b0;
    rf_wa = ir[RB_LSB +: 3];
    rf_wd = mem_q;
    case (ctrl.rf_src)
      RF_ALU: begin
        rf_we = 1'b1;
        rf_wa = ir[2:0];
        rf_wd = alu_q;
      end
      RF_MEMQ: begin
        rf_we = !fault;
      end
      RF_LINK: begin
        rf_we = 1'b1;
        rf_wd = 32'(pc) + 32'd1;
      end
      default: begin
        rf_we = 1'b0;
      end
    endcase
  end

  // Register file
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 8; i++) begin
        regs[i] <= '0;
      end
    end else if (rf_we) begin
      regs[rf_wa] <= rf_wd;
    end
  end

  // Latch instruction and operands
  always_ff @(posedge clk) begin
    if (ctrl.dec) begin
      ir    <= mem_q[IR_W-1:0];
      a_val <= regs[mem_q[RA_LSB +: 3]];
      b_val <= regs[mem_q[RB_LSB +: 3]];
    end
  end

  // Execute: ALU result, effective address and next pc
  always_ff @(posedge clk) begin
    if (ctrl.exec) begin
      alu_q <= (opc == OP_ADD) ? (a_val + b_val) : ~(a_val | b_val);
      ea    <= addr33[MEM_AW-1:0];
      fault <= addr33[32] || (addr33 >= 33'(MEM_WORDS));
      case (opc)
        OP_BEQ: begin
          next_pc <= (a_val == b_val) ? (pc_inc + off32[MEM_AW-1:0]) : pc_inc;
        end
        OP_JALR: begin
          next_pc <= (ir[RA_LSB +: 3] == ir[RB_LSB +: 3]) ? pc_inc : a_val[MEM_AW-1:0];
        end
        default: begin
          next_pc <= pc_inc;
        end
      endcase
    end
  end

  // Commit pc, halt flag and count
  always_ff @(posedge clk) begin
    if (rst) begin
      pc         <= '0;
      halt_flag  <= 1'b0;
      step_count <= '0;
      done       <= 1'b0;
    end else begin
      done <= ctrl.finish;
      if (ctrl.commit) begin
        pc <= next_pc;
        if (step_count != '1) begin
          step_count <= step_count + 32'd1;
        end
      end
      if (ctrl.halt_set) begin
        halt_flag <= 1'b1;
      end
    end
  end

  // Result beat payload
  always_ff @(posedge clk) begin
    if (ctrl.finish) begin
      opc_out   <= ctrl.commit ? opc : OP_NOOP;
      fault_out <= ctrl.commit && (opc == OP_LW || opc == OP_SW) && fault;
    end
  end

  assign stat.opcode           = opc;
  assign stat.halted           = halt_flag;
  assign program_counter       = 16'(pc);
  assign executed_opcode       = opc_out;
  assign halted                = halt_flag;
  assign address_fault         = fault_out;
  assign instructions_executed = step_count;

endmodule

`default_nettype wire

>>> hw/rtl/lc2k_instruction_executor.sv
// Top level of the LC-2K executor: sequencer plus datapath, with checks.
// Depends on lc2k_pkg, lc2k_seq and lc2k_datapath.
`default_nettype none

// An item is taken on a clock edge with start high and busy low. A load beat
// (op = 0) writes one memory word; a step beat (op = 1) executes the
// instruction at the program counter. Each item yields exactly one result
// beat, shown for one cycle with done high; the receiver cannot stall it, so
// capture the outputs whenever done is high. Microprogram steps per item (the
// pc word is read while idle, so no fetch step is spent): load beats and
// steps after halt use only the load or skip step; add, nor, sw, beq, jalr,
// halt and noop run decode, execute and a result step; lw runs decode,
// execute, read and write-back. A new item may be started in the cycle its
// predecessor's result is shown. No clearing pass is needed after reset;
// memory words read before being written return arbitrary data.
module lc2k_instruction_executor (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output      logic        busy,
  input  wire logic        op,
  input  wire logic [15:0] load_address,
  input  wire logic [31:0] load_data,
  output      logic        done,
  output      logic [15:0] program_counter,
  output      logic [2:0]  executed_opcode,
  output      logic        halted,
  output      logic        address_fault,
  output      logic [31:0] instructions_executed
);
  import lc2k_pkg::*;

  ctrl_t   ctrl;
  status_t stat;

  lc2k_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .op    (op),
    .stat  (stat),
    .ctrl  (ctrl),
    .busy  (busy)
  );

  lc2k_datapath u_dp (
    .clk                   (clk),
    .rst                   (rst),
    .ctrl                  (ctrl),
    .load_address          (load_address),
    .load_data             (load_data),
    .stat                  (stat),
    .program_counter       (program_counter),
    .executed_opcode       (executed_opcode),
    .halted                (halted),
    .address_fault         (address_fault),
    .instructions_executed (instructions_executed),
    .done                  (done)
  );

  // Never show two result beats back to back
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result beat repeated");

  // Leaving busy always delivers a result beat
  a_busy_done: assert property (@(posedge clk) disable iff (rst)
    (!busy && $past(busy)) |-> done)
    else $error("busy dropped without a result beat");

  // Halt is sticky until reset
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    $past(halted) |-> halted)
    else $error("halt flag cleared");

  // The count moves only with a result beat
  a_count_done: assert property (@(posedge clk) disable iff (rst)
    (instructions_executed != $past(instructions_executed)) |-> done)
    else $error("count changed without a result beat");

  // Faults come only from lw or sw
  a_fault_mem: assert property (@(posedge clk) disable iff (rst)
    (done && address_fault) |-> (executed_opcode == OP_LW || executed_opcode == OP_SW))
    else $error("address fault on a non-memory instruction");

endmodule

`default_nettype wire
